/* rtl/pov_pkg.sv */
// ----------------------------------------------------------------------------
// pov_pkg
// Shared types, register codes, font table and helper functions of the
// swing-timed column sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pov_pkg;

    localparam int unsigned MAX_CHARS   = 8;
    localparam int unsigned DIV_STEPS   = 19;

    localparam logic [15:0] END_THRESHOLD_RESET   = 16'd14000;
    localparam logic [15:0] START_THRESHOLD_RESET = 16'd1500;
    localparam logic [15:0] COLUMN_TIME_RESET     = 16'd100;
    localparam logic [15:0] TIMER_MAX             = 16'hFFFF;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;

    // configuration register indexes
    localparam logic [1:0] REG_MESSAGE_CHARS   = 2'd0;
    localparam logic [1:0] REG_MESSAGE_LENGTH  = 2'd1;
    localparam logic [1:0] REG_END_THRESHOLD   = 2'd2;
    localparam logic [1:0] REG_START_THRESHOLD = 2'd3;

    // glyph columns, column 0 in bits 7:0
    localparam logic [23:0] GLYPH_ROWS [26] = '{
        24'hFF09FF, 24'hF090FF, 24'h8181FF, 24'hFF90F0, 24'h9191FF, 24'h0909FF,
        24'hF191FF, 24'hFF08FF, 24'h81FF81, 24'h01FF81, 24'h4224FF, 24'h8080FF,
        24'hFF0FFF, 24'hFF01FF, 24'hFF81FF, 24'h0F09FF, 24'hBF613F, 24'h1010F0,
        24'hF1919F, 24'h08FF08, 24'hFF80FF, 24'h608060, 24'hFFF0FF, 24'hC33CC3,
        24'h0FF80F, 24'h8799E1
    };

    typedef struct packed {
        logic capture;
        logic div_load;
        logic div_step;
        logic commit;
    } pov_cmd_t;

    typedef struct packed {
        logic start_sweep;
        logic div_done;
        logic out_free;
    } pov_status_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CHAR_A) && (c <= CHAR_Z);
    endfunction

    // glyph columns plus two gap columns
    function automatic logic [2:0] char_width(input logic [7:0] c);
        logic [2:0] w;
        if (c == CHAR_SPACE)
            w = 3'd4;
        else if (is_letter(c))
            w = 3'd5;
        else
            w = 3'd2;
        return w;
    endfunction

    function automatic logic [7:0] glyph_column(input logic [7:0] c, input logic [2:0] col);
        logic [7:0]  idx;
        logic [23:0] row;
        logic [7:0]  bits;
        idx  = c - CHAR_A;
        row  = GLYPH_ROWS[idx[4:0]];
        bits = 8'd0;
        if (is_letter(c))
        begin
            case (col)
                3'd0:    bits = row[7:0];
                3'd1:    bits = row[15:8];
                3'd2:    bits = row[23:16];
                default: bits = 8'd0;
            endcase
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

/* rtl/pov_level_if.sv */
// ----------------------------------------------------------------------------
// pov_level_if
// Input channel: one comparator level per tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface pov_level_if;
    logic valid;
    logic ready;
    logic comparator_level;

    modport source (output valid, output comparator_level, input ready);
    modport sink (input valid, input comparator_level, output ready);
endinterface

`default_nettype wire

/* rtl/pov_column_if.sv */
// ----------------------------------------------------------------------------
// pov_column_if
// Output channel: LED column and sweep flag for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface pov_column_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_column;
    logic       sweep_active;

    modport source (output valid, output led_column, output sweep_active, input ready);
    modport sink (input valid, input led_column, input sweep_active, output ready);
endinterface

`default_nettype wire

/* rtl/pov_controller.sv */
// ----------------------------------------------------------------------------
// pov_controller
// Sequences one tick: capture, evaluate, optional divide, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module pov_controller
    import pov_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire pov_status_t status,
    output pov_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.start_sweep)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                    state_next = ST_COMMIT;
                else
                    cmd.div_step = 1'b1;
            end
            ST_COMMIT:
            begin
                // hold here while the previous beat is still unread
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/pov_datapath.sv */
// ----------------------------------------------------------------------------
// pov_datapath
// Configuration registers, swing timer, sweep position, serial divider
// for the column time and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pov_datapath
    import pov_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        level,
    input  wire pov_cmd_t    cmd,
    output pov_status_t      status,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       led_column,
    output logic             sweep_active
);

    // configuration
    logic [63:0] message_reg;
    logic [3:0]  length_reg;
    logic [15:0] end_th_reg;
    logic [15:0] start_th_reg;

    // tick state
    logic        level_reg;
    logic [15:0] timer_reg;
    logic [15:0] timer_next;
    logic        last_level_reg;
    logic        sweeping_reg;
    logic        sweeping_next;
    logic [2:0]  char_pos_reg;
    logic [2:0]  char_pos_next;
    logic [2:0]  col_pos_reg;
    logic [2:0]  col_pos_next;
    logic [15:0] hold_reg;
    logic [15:0] hold_next;
    logic [15:0] col_time_reg;
    logic [15:0] col_time_next;

    // divider
    logic [8:0]  divisor_reg;
    logic [8:0]  rem_reg;
    logic [18:0] quo_reg;
    logic [4:0]  div_count_reg;
    logic [9:0]  div_trial;
    logic        div_fits;

    // output register
    logic        out_valid_reg;
    logic [7:0]  led_reg;
    logic [7:0]  led_next;
    logic        active_reg;
    logic        active_next;

    logic [3:0]  chars_used;
    logic [5:0]  total_cols;
    logic [2:0]  last_char;
    logic        edge_seen;
    logic        start_edge;
    logic        abort_edge;

    always_comb
    begin
        chars_used = (length_reg > 4'(MAX_CHARS)) ? 4'(MAX_CHARS) : length_reg;
        last_char  = 3'(chars_used - 4'd1);
        total_cols = 6'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (4'(k) < chars_used)
                total_cols = total_cols + 6'(char_width(message_reg[8*k +: 8]));
        end
    end

    assign edge_seen  = level_reg != last_level_reg;
    assign start_edge = edge_seen && level_reg && (timer_reg > start_th_reg);
    assign abort_edge = edge_seen && !level_reg && (timer_reg > end_th_reg);

    assign status.start_sweep = start_edge && (total_cols != 6'd0);
    assign status.div_done    = div_count_reg == 5'd0;
    assign status.out_free    = !out_valid_reg || out_ready;

    // restoring divider, one quotient bit a step
    assign div_trial = {rem_reg, quo_reg[18]};
    assign div_fits  = div_trial >= {1'b0, divisor_reg};

    // one tick of the sweep, evaluated when the beat is committed
    always_comb
    begin
        logic        sw1;
        logic [2:0]  cp1;
        logic [2:0]  col1;
        logic [15:0] hc1;
        logic [15:0] hc2;
        logic [15:0] hold;
        logic [7:0]  cur_char;
        logic [7:0]  prev_char;
        logic [2:0]  prev_pos;

        sw1        = sweeping_reg;
        cp1        = char_pos_reg;
        col1       = col_pos_reg;
        hc1        = hold_reg;
        col_time_next = col_time_reg;
        timer_next = timer_reg;

        if (start_edge)
        begin
            if (total_cols != 6'd0)
            begin
                col_time_next = quo_reg[15:0];
                sw1  = 1'b1;
                cp1  = last_char;
                col1 = char_width(message_reg[{last_char, 3'b000} +: 8]) - 3'd1;
                hc1  = 16'd0;
            end
            timer_next = 16'd0;
        end
        else if (abort_edge)
        begin
            sw1        = 1'b0;
            hc1        = 16'd0;
            timer_next = 16'd0;
        end
        else if (timer_reg != TIMER_MAX)
        begin
            timer_next = timer_reg + 16'd1;
        end

        cur_char  = message_reg[{cp1, 3'b000} +: 8];
        prev_pos  = cp1 - 3'd1;
        prev_char = message_reg[{prev_pos, 3'b000} +: 8];
        hold      = (col_time_next == 16'd0) ? 16'd1 : col_time_next;
        hc2       = (hc1 == TIMER_MAX) ? hc1 : hc1 + 16'd1;

        sweeping_next = sw1;
        char_pos_next = cp1;
        col_pos_next  = col1;
        hold_next     = hc1;
        led_next      = 8'd0;
        active_next   = 1'b0;

        if (sw1)
        begin
            active_next = 1'b1;
            if ({1'b0, cp1} < chars_used)
                led_next = glyph_column(cur_char, col1);
            hold_next = hc2;
            if (hc2 >= hold)
            begin
                hold_next = 16'd0;
                if (col1 != 3'd0)
                begin
                    col_pos_next = col1 - 3'd1;
                end
                else if (cp1 != 3'd0)
                begin
                    char_pos_next = prev_pos;
                    col_pos_next  = char_width(prev_char) - 3'd1;
                end
                else
                begin
                    sweeping_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_reg <= 64'd0;
            length_reg  <= 4'd0;
            end_th_reg  <= END_THRESHOLD_RESET;
            start_th_reg <= START_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MESSAGE_CHARS:   message_reg  <= cfg_data;
                REG_MESSAGE_LENGTH:  length_reg   <= cfg_data[3:0];
                REG_END_THRESHOLD:   end_th_reg   <= cfg_data[15:0];
                REG_START_THRESHOLD: start_th_reg <= cfg_data[15:0];
                default:             message_reg  <= message_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg      <= 16'd0;
            last_level_reg <= 1'b0;
            sweeping_reg   <= 1'b0;
            char_pos_reg   <= 3'd0;
            col_pos_reg    <= 3'd0;
            hold_reg       <= 16'd0;
            col_time_reg   <= COLUMN_TIME_RESET;
        end
        else if (cmd.commit)
        begin
            timer_reg      <= timer_next;
            last_level_reg <= level_reg;
            sweeping_reg   <= sweeping_next;
            char_pos_reg   <= char_pos_next;
            col_pos_reg    <= col_pos_next;
            hold_reg       <= hold_next;
            col_time_reg   <= col_time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_count_reg <= 5'd0;
        else if (cmd.div_load)
            div_count_reg <= 5'(DIV_STEPS);
        else if (cmd.div_step)
            div_count_reg <= div_count_reg - 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            level_reg <= level;
        if (cmd.div_load)
        begin
            // timer * 5 over 12 * columns
            divisor_reg <= {total_cols, 3'b000} + {1'b0, total_cols, 2'b00};
            rem_reg     <= 9'd0;
            quo_reg     <= {1'b0, timer_reg, 2'b00} + {3'b000, timer_reg};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_fits ? 9'(div_trial - {1'b0, divisor_reg}) : div_trial[8:0];
            quo_reg <= {quo_reg[17:0], div_fits};
        end
        if (cmd.commit)
        begin
            led_reg    <= led_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid    = out_valid_reg;
    assign led_column   = led_reg;
    assign sweep_active = active_reg;

endmodule

`default_nettype wire

/* rtl/swing_timed_pov_column_sequencer_top.sv */
// ----------------------------------------------------------------------------
// swing_timed_pov_column_sequencer_top
// Swing-timed persistence-of-vision column sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   level  : one beat per timer tick carrying the comparator level.
//   column : one beat per input beat with the LED column and sweep flag.
//   cfg_*  : writes of message chars, length, end and start thresholds;
//            the user must make them with no tick in flight; not enforced.
// Timing:
//   without a sweep start a tick is captured, evaluated and committed, and
//   the result register is loaded at the commit; a sweep start adds the
//   serial divider of the column time (19 quotient bits, one a cycle)
//   between evaluation and commit.
//   The next tick is taken once the previous one has been committed, even
//   while its result still waits.
// Reset:
//   timer, positions and sweep cleared, column time 100, thresholds
//   14000 and 1500, empty message; no beat is presented.
// Stall:
//   the result register holds its beat until column.ready; a finished
//   tick waits in the commit step until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module swing_timed_pov_column_sequencer_top
    import pov_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    pov_level_if.sink        level,
    pov_column_if.source     column
);

    pov_cmd_t    cmd;
    pov_status_t status;

    pov_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (level.valid),
        .in_ready (level.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pov_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .level        (level.comparator_level),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (column.valid),
        .out_ready    (column.ready),
        .led_column   (column.led_column),
        .sweep_active (column.sweep_active)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the swing-timed column sequencer. Every accepted
// comparator tick is run through a local model of the swing timer, the
// sweep start and abort rules and the column walk. Each column beat is
// checked against the oldest expected beat. Both handshakes idle at random.
// The receiver makes one long hold-off, and one long swing ends in a full
// sweep of an eight-letter message.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
    import pov_pkg::*;
();

    localparam int unsigned SETTLE_CYCLES  = 30;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_TICKS    = 120;
    localparam int unsigned HOLD_OFF_LONG  = 250;
    localparam int unsigned SWING_TICKS    = 100;
    localparam int unsigned SWEEP_TICKS    = 150;

    // font: three columns per letter, column 0 first
    localparam logic [0:77][7:0] FONT = {
        8'hFF, 8'h09, 8'hFF,  8'hFF, 8'h90, 8'hF0,  8'hFF, 8'h81, 8'h81,
        8'hF0, 8'h90, 8'hFF,  8'hFF, 8'h91, 8'h91,  8'hFF, 8'h09, 8'h09,
        8'hFF, 8'h91, 8'hF1,  8'hFF, 8'h08, 8'hFF,  8'h81, 8'hFF, 8'h81,
        8'h81, 8'hFF, 8'h01,  8'hFF, 8'h24, 8'h42,  8'hFF, 8'h80, 8'h80,
        8'hFF, 8'h0F, 8'hFF,  8'hFF, 8'h01, 8'hFF,  8'hFF, 8'h81, 8'hFF,
        8'hFF, 8'h09, 8'h0F,  8'h3F, 8'h61, 8'hBF,  8'hF0, 8'h10, 8'h10,
        8'h9F, 8'h91, 8'hF1,  8'h08, 8'hFF, 8'h08,  8'hFF, 8'h80, 8'hFF,
        8'h60, 8'h80, 8'h60,  8'hFF, 8'hF0, 8'hFF,  8'hC3, 8'h3C, 8'hC3,
        8'h0F, 8'hF8, 8'h0F,  8'hE1, 8'h99, 8'h87
    };

    typedef struct packed {
        logic [63:0] chars;
        logic [3:0]  len;
        logic [15:0] end_th;
        logic [15:0] start_th;
    } setting_t;

    typedef struct packed {
        logic [7:0] led;
        logic       active;
    } column_t;

    typedef struct packed {
        logic [1:0] setting;
        logic       lvl;
        logic       typed;
        logic [7:0] led;
        logic       active;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    pov_level_if  lv ();
    pov_column_if col ();

    swing_timed_pov_column_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .level     (lv),
        .column    (col)
    );

    always #2 clk = ~clk;

    // register copies and sequencer state of the local model
    logic [63:0] msg_chars;
    logic [3:0]  msg_len;
    logic [15:0] end_th;
    logic [15:0] start_th;
    logic [15:0] swing_timer;
    logic        last_lvl;
    logic        sweeping;
    logic [2:0]  char_pos;
    logic [2:0]  col_pos;
    logic [15:0] hold_count;
    logic [15:0] column_time;

    column_t column_expect [$];

    bit          idling_on = 1'b1;
    int unsigned hold_off = 0;
    int unsigned mismatches = 0;
    int unsigned beats_checked = 0;
    int unsigned ticks_sent = 0;
    int unsigned sweeps_started = 0;
    int unsigned settings_loaded = 0;

    setting_t dir_settings [1:2] = '{
        // A, space, Z, and a code with no glyph; falling edges never abort
        '{64'hFFFF_FFFF_3F5A_2041, 4'd4, 16'hFFFF, 16'd0},
        // length past the limit, starts impossible, any falling edge aborts
        '{64'h4D4D_4D4D_4D4D_4D4D, 4'd15, 16'd0, 16'hFFFF}
    };

    row_t dir_rows [20] = '{
        '{2'd0, 1'b0, 1'b1, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b1, 8'h00, 1'b0},
        '{2'd0, 1'b0, 1'b1, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b1, 8'h00, 1'b0},
        '{2'd0, 1'b0, 1'b1, 8'h00, 1'b0},
        '{2'd1, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd2, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{2'd0, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    function automatic int unsigned used_chars();
        return (msg_len > 4'd8) ? 8 : int'(msg_len);
    endfunction

    function automatic logic [7:0] char_code(input int unsigned k);
        return msg_chars[(k % 8) * 8 +: 8];
    endfunction

    // glyph plus the two gap columns
    function automatic int unsigned char_columns(input int unsigned k);
        logic [7:0] c;
        c = char_code(k);
        if (c == CHAR_SPACE)
            return 4;
        if (c >= CHAR_A && c <= CHAR_Z)
            return 5;
        return 2;
    endfunction

    function automatic logic [7:0] column_pattern(input int unsigned k, input int unsigned cidx);
        logic [7:0] c;
        if (k >= used_chars())
            return 8'h00;
        c = char_code(k);
        if (c >= CHAR_A && c <= CHAR_Z && cidx < 3)
            return FONT[int'(c - CHAR_A) * 3 + cidx];
        return 8'h00;
    endfunction

    function automatic int unsigned message_columns();
        int unsigned n;
        n = 0;
        for (int unsigned k = 0; k < used_chars(); k++)
            n += char_columns(k);
        return n;
    endfunction

    function automatic setting_t random_setting();
        setting_t    s;
        int unsigned pick;
        for (int k = 0; k < 8; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                s.chars[k * 8 +: 8] = CHAR_SPACE;
            else if (pick == 1)
                s.chars[k * 8 +: 8] = 8'($urandom_range(0, 255));
            else
                s.chars[k * 8 +: 8] = CHAR_A + 8'($urandom_range(0, 25));
        end
        s.len      = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
        s.end_th   = 16'($urandom_range(0, 80));
        s.start_th = 16'($urandom_range(0, 40));
        return s;
    endfunction

    task automatic reset_model();
        msg_chars   = '0;
        msg_len     = '0;
        end_th      = END_THRESHOLD_RESET;
        start_th    = START_THRESHOLD_RESET;
        swing_timer = '0;
        last_lvl    = 1'b0;
        sweeping    = 1'b0;
        char_pos    = '0;
        col_pos     = '0;
        hold_count  = '0;
        column_time = COLUMN_TIME_RESET;
    endtask

    // one tick: edge rules first, then the column walk
    task automatic predict_tick(input logic lvl, output logic [7:0] led, output logic active);
        logic        changed;
        int unsigned n;
        int unsigned last;
        int unsigned hold;
        changed  = (lvl != last_lvl);
        last_lvl = lvl;
        led      = 8'h00;
        active   = 1'b0;
        if (changed && lvl && swing_timer > start_th)
        begin
            n = message_columns();
            if (n > 0)
            begin
                column_time = 16'((swing_timer * 32'd5) / (12 * n));
                last        = used_chars() - 1;
                sweeping    = 1'b1;
                char_pos    = 3'(last);
                col_pos     = 3'(char_columns(last) - 1);
                hold_count  = '0;
                sweeps_started++;
            end
            swing_timer = '0;
        end
        else if (changed && !lvl && swing_timer > end_th)
        begin
            sweeping    = 1'b0;
            hold_count  = '0;
            swing_timer = '0;
        end
        else if (swing_timer != 16'hFFFF)
            swing_timer++;

        if (sweeping)
        begin
            hold   = (column_time == 0) ? 1 : int'(column_time);
            led    = column_pattern(char_pos, col_pos);
            active = 1'b1;
            if (hold_count != 16'hFFFF)
                hold_count++;
            if (hold_count >= hold)
            begin
                hold_count = '0;
                if (col_pos > 0)
                    col_pos--;
                else if (char_pos > 0)
                begin
                    char_pos--;
                    col_pos = 3'(char_columns(char_pos) - 1);
                end
                else
                    sweeping = 1'b0;
            end
        end
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // called right after a rising edge; valid stays high after the beat
    task automatic send_tick(input logic lvl, input logic typed, input logic [7:0] t_led,
                             input logic t_act);
        int unsigned gap;
        logic [7:0]  p_led;
        logic        p_act;
        gap = idling_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            lv.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        lv.valid            <= 1'b1;
        lv.comparator_level <= lvl;
        do @(posedge clk); while (!lv.ready);
        predict_tick(lvl, p_led, p_act);
        if (typed)
            column_expect.push_back('{t_led, t_act});
        else
            column_expect.push_back('{p_led, p_act});
        ticks_sent++;
    endtask

    // registers change only once every column beat is home
    task automatic load_setting(input setting_t s);
        lv.valid <= 1'b0;
        while (column_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MESSAGE_CHARS;
        cfg_data  <= s.chars;
        @(posedge clk);
        cfg_index <= REG_MESSAGE_LENGTH;
        cfg_data  <= {60'd0, s.len};
        @(posedge clk);
        cfg_index <= REG_END_THRESHOLD;
        cfg_data  <= {48'd0, s.end_th};
        @(posedge clk);
        cfg_index <= REG_START_THRESHOLD;
        cfg_data  <= {48'd0, s.start_th};
        @(posedge clk);
        cfg_write <= 1'b0;
        msg_chars = s.chars;
        msg_len   = s.len;
        end_th    = s.end_th;
        start_th  = s.start_th;
        settings_loaded++;
    endtask

    // column receiver
    initial
    begin
        int unsigned stall;
        column_t     want;
        col.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off > 0)
            begin
                stall    = hold_off;
                hold_off = 0;
            end
            else
                stall = idling_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                col.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            col.ready <= 1'b1;
            do @(posedge clk); while (!col.valid);
            beats_checked++;
            if (column_expect.size() == 0)
                note_mismatch("unexpected beat, led_column", 0, col.led_column);
            else
            begin
                want = column_expect.pop_front();
                if (col.led_column !== want.led)
                    note_mismatch("led_column", want.led, col.led_column);
                if (col.sweep_active !== want.active)
                    note_mismatch("sweep_active", want.active, col.sweep_active);
            end
        end
    end

    initial
    begin
        #(60_000_000);
        $display("timeout with %0d column beats outstanding", column_expect.size());
        $display("FAIL swing_timed_pov_column_sequencer_top");
        $finish;
    end

    initial
    begin
        setting_t    s;
        int unsigned sent;
        int unsigned run;
        int unsigned span;
        logic        lvl;
        reset_model();
        cfg_write           <= 1'b0;
        cfg_index           <= REG_MESSAGE_CHARS;
        cfg_data            <= '0;
        lv.valid            <= 1'b0;
        lv.comparator_level <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].setting != 2'd0)
                load_setting(dir_settings[dir_rows[i].setting]);
            send_tick(dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].led, dir_rows[i].active);
        end
        lvl = 1'b0;

        // mostly swings held for about the thresholds, some single-tick noise
        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
        begin
            s = random_setting();
            if (p == 0)
            begin
                s.chars    = '1;
                s.len      = 4'd8;
                s.end_th   = '0;
                s.start_th = '0;
            end
            else if (p == 1)
            begin
                s.chars = '0;
                s.len   = '0;
            end
            else if (p == 2)
                s.end_th = 16'hFFFF;
            else if (p == 3)
            begin
                s.chars[7:0] = CHAR_SPACE;
                s.len        = 4'd1;
            end
            load_setting(s);
            span = (s.start_th > s.end_th) ? s.start_th : s.end_th;
            if (span > 60)
                span = 60;
            sent = 0;
            while (sent < PHASE_TICKS)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    run = $urandom_range(1, span * 2 + 6);
                    lvl = ~lvl;
                    repeat (run) send_tick(lvl, 1'b0, 8'h00, 1'b0);
                    sent += run;
                end
                else
                begin
                    lvl = 1'($urandom_range(0, 1));
                    send_tick(lvl, 1'b0, 8'h00, 1'b0);
                    sent++;
                end
            end
        end

        // receiver stalls for a long stretch while ticks keep coming
        hold_off = HOLD_OFF_LONG;
        repeat (40)
        begin
            lvl = 1'($urandom_range(0, 1));
            send_tick(lvl, 1'b0, 8'h00, 1'b0);
        end

        // a long swing, then hold the level while the whole message sweeps
        s = '{64'h474E_4950_4545_5753, 4'd8, 16'hFFFF, 16'd90};
        load_setting(s);
        idling_on = 1'b0;
        repeat (SWING_TICKS) send_tick(1'b0, 1'b0, 8'h00, 1'b0);
        repeat (SWEEP_TICKS) send_tick(1'b1, 1'b0, 8'h00, 1'b0);
        idling_on = 1'b1;

        lv.valid <= 1'b0;
        span = 0;
        while (column_expect.size() != 0 && span < 20000)
        begin
            @(posedge clk);
            span++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (column_expect.size() != 0)
        begin
            $display("%0d expected column beats never arrived", column_expect.size());
            mismatches += column_expect.size();
        end

        $display("covered %0d ticks under %0d register settings, %0d sweeps started",
                 ticks_sent, settings_loaded, sweeps_started);
        $display("%0d column beats checked, %0d mismatches", beats_checked, mismatches);
        if (mismatches == 0)
            $display("PASS swing_timed_pov_column_sequencer_top");
        else
            $display("FAIL swing_timed_pov_column_sequencer_top");
        $finish;
    end

endmodule

/* sim.f */
rtl/pov_pkg.sv
rtl/pov_level_if.sv
rtl/pov_column_if.sv
rtl/pov_controller.sv
rtl/pov_datapath.sv
rtl/swing_timed_pov_column_sequencer_top.sv
bench/tb.sv
